@@ hdl/assert_macros.svh @@
// Assertion macros shared by the table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on clk outside reset.
`define NKT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on clk outside reset.
`define NKT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hdl/nkt_pkg.sv @@
// Types, codes and helper functions of the name-keyed table.
package nkt_pkg;
	localparam int NAME_BYTES  = 30;
	localparam int KIND_BYTES  = 20;
	localparam int MAX_RESULTS = 16;

	localparam logic [2:0] REQ_APPEND = 3'd0;
	localparam logic [2:0] REQ_LIST   = 3'd1;
	localparam logic [2:0] REQ_SEQ    = 3'd2;
	localparam logic [2:0] REQ_BIN    = 3'd3;
	localparam logic [2:0] REQ_SORT   = 3'd4;
	localparam logic [2:0] REQ_REMOVE = 3'd5;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_NOT_FOUND = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_EMPTY     = 3'd3;
	localparam logic [2:0] STS_UNSORTED  = 3'd4;

	typedef struct packed {
		logic [255:0]       name;
		logic [191:0]       kind;
		logic signed [31:0] amount;
	} entry_t;

	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_res_t;

	typedef struct packed {
		logic [2:0] status;
		entry_t     entry;
		logic [6:0] ops;
		logic [3:0] slot;
		logic       last;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE, S_APPEND, S_LREAD, S_LDATA, S_SREAD, S_SCMP, S_CREAD, S_CCMP,
		S_BREAD, S_BCMP, S_XREAD, S_XCMP, S_XW1, S_XW2, S_RREAD, S_RWR, S_OWAIT
	} state_t;

	// Keeps bytes up to the first zero byte or maxc characters, zeroes the rest.
	function automatic logic [255:0] norm_str(input logic [255:0] s, input int maxc);
		logic         ended;
		logic [255:0] r;
		ended = 1'b0;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (s[8*i +: 8] == 8'h00 || i >= maxc)
				ended = 1'b1;
			if (!ended)
				r[8*i +: 8] = s[8*i +: 8];
		end
		return r;
	endfunction

	function automatic logic [6:0] sat_inc(input logic [6:0] v);
		return (v == 7'h7f) ? v : v + 7'd1;
	endfunction
endpackage

@@ hdl/nkt_store.sv @@
// Entry memory: one write port and two registered read ports.
module nkt_store #(
	parameter int CAPACITY = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(CAPACITY)-1:0]  waddr,
	input  nkt_pkg::entry_t              wdata,
	input  logic                         re,
	input  logic [$clog2(CAPACITY)-1:0]  raddr_a,
	input  logic [$clog2(CAPACITY)-1:0]  raddr_b,
	output nkt_pkg::entry_t              rdata_a,
	output nkt_pkg::entry_t              rdata_b
);
	import nkt_pkg::*;

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Read data holds while re is low, so a pair can be swapped back.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

@@ hdl/nkt_cmp.sv @@
// Case-folding name comparator shared by every search and sort step.
module nkt_cmp (
	input  logic [255:0]      a,
	input  logic [255:0]      b,
	output nkt_pkg::cmp_res_t res
);
	import nkt_pkg::*;

	logic [255:0] fa;
	logic [255:0] fb;

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
	endfunction

	// The first character goes to the top so one magnitude compare is lexicographic.
	always_comb begin
		for (int k = 0; k < 32; k++) begin
			fa[(31-k)*8 +: 8] = fold(a[8*k +: 8]);
			fb[(31-k)*8 +: 8] = fold(b[8*k +: 8]);
		end
	end

	assign res.lt = fa < fb;
	assign res.gt = fa > fb;
endmodule

@@ hdl/name_keyed_table_sort_search.sv @@
// Top level of the name-keyed table: sequencer, entry memory and comparator.
// A table of up to CAPACITY entries kept in a memory with one write and two
// read ports; every search, sortedness check and sort step runs through a
// single name comparator, one table access and one compare per step. A
// request is taken only when the block is idle (in_stall low) and is done when
// its last word has been taken on the output, except a remove, which then
// shifts the later entries down. Append writes one entry; list reads and
// sends each entry in turn; sequential search and remove compare one entry
// per step, remove then reads and writes each later entry one slot down;
// binary search checks each neighbouring pair for order, then compares one
// probe per step; bubble sort compares a pair per step, swapping it if out
// of order. Unknown request codes are dropped.
`include "assert_macros.svh"
module name_keyed_table_sort_search #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [63:0]        name_w0,
	input  logic [63:0]        name_w1,
	input  logic [63:0]        name_w2,
	input  logic [63:0]        name_w3,
	input  logic [63:0]        kind_w0,
	input  logic [63:0]        kind_w1,
	input  logic [63:0]        kind_w2,
	input  logic signed [31:0] amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [63:0]        out_name_w0,
	output logic [63:0]        out_name_w1,
	output logic [63:0]        out_name_w2,
	output logic [63:0]        out_name_w3,
	output logic [63:0]        out_kind_w0,
	output logic [63:0]        out_kind_w1,
	output logic [63:0]        out_kind_w2,
	output logic signed [31:0] out_amount,
	output logic [6:0]         op_count,
	output logic [3:0]         slot,
	output logic               last
);
	import nkt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d, ret_q, ret_d;
	logic [2:0]         req_q;
	logic [255:0]       key_q;
	logic [191:0]       knorm_q;
	logic signed [31:0] amt_q;
	logic [CW-1:0] n_q, n_d, i_q, i_d, end_q, end_d, lo_q, lo_d, hic_q, hic_d;
	logic [CW-1:0] ip1;
	logic [IW-1:0] mid_q, mid_d;
	logic [6:0]    ops_q, ops_d;
	logic          out_valid_q;
	result_t       out_q, em;
	logic          emit;

	logic          we, re;
	logic [IW-1:0] waddr, ra, rb;
	entry_t        wdata, rd_a, rd_b;
	logic [255:0]  cmp_b;
	cmp_res_t      cres;
	logic          eq;

	logic [255:0] key_in, kind_in;
	logic [CW:0]  msum;
	logic [CW-1:0] midc, lo_n, hic_n;
	int            lcnt;

	assign key_in  = norm_str({name_w3, name_w2, name_w1, name_w0}, NAME_BYTES - 1);
	assign kind_in = norm_str({64'h0, kind_w2, kind_w1, kind_w0}, KIND_BYTES - 1);
	assign ip1     = i_q + 1'b1;
	assign eq      = !cres.lt && !cres.gt;
	assign lcnt    = (int'(n_q) > MAX_RESULTS) ? MAX_RESULTS : int'(n_q);
	assign msum    = {1'b0, lo_q} + {1'b0, hic_q} - 1'b1;
	assign midc    = CW'(mid_q);

	assign cmp_b = (state_q == S_CCMP || state_q == S_XCMP) ? rd_b.name : key_q;

	nkt_store #(.CAPACITY(CAPACITY)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .re(re),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(rd_a), .rdata_b(rd_b)
	);

	nkt_cmp u_cmp (.a(rd_a.name), .b(cmp_b), .res(cres));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		n_d     = n_q;
		i_d     = i_q;
		end_d   = end_q;
		lo_d    = lo_q;
		hic_d   = hic_q;
		mid_d   = mid_q;
		ops_d   = ops_q;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = i_q[IW-1:0];
		wdata   = rd_a;
		ra      = i_q[IW-1:0];
		rb      = ip1[IW-1:0];
		emit    = 1'b0;
		em      = '0;
		em.last = 1'b1;
		lo_n    = lo_q;
		hic_n   = hic_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ops_d = '0;
					i_d   = '0;
					case (req_type)
						REQ_APPEND: state_d = S_APPEND;
						REQ_LIST: begin
							if (n_q == '0) begin
								emit      = 1'b1;
								em.status = STS_EMPTY;
							end else
								state_d = S_LREAD;
						end
						REQ_SEQ, REQ_REMOVE: begin
							if (n_q == '0) begin
								emit      = 1'b1;
								em.status = STS_EMPTY;
							end else
								state_d = S_SREAD;
						end
						REQ_BIN: begin
							if (n_q == '0) begin
								emit      = 1'b1;
								em.status = STS_EMPTY;
							end else if (n_q == CW'(1)) begin
								lo_d    = '0;
								hic_d   = n_q;
								state_d = S_BREAD;
							end else
								state_d = S_CREAD;
						end
						REQ_SORT: begin
							if (n_q <= CW'(1))
								emit = 1'b1;
							else begin
								end_d   = n_q - 1'b1;
								state_d = S_XREAD;
							end
						end
						default: ;
					endcase
				end
			end
			S_APPEND: begin
				if (n_q == CW'(CAPACITY)) begin
					emit      = 1'b1;
					em.status = STS_FULL;
				end else begin
					we        = 1'b1;
					waddr     = n_q[IW-1:0];
					wdata     = '{name: key_q, kind: knorm_q, amount: amt_q};
					n_d       = n_q + 1'b1;
					emit      = 1'b1;
					em.entry  = wdata;
					em.slot   = 4'(n_q);
				end
			end
			S_LREAD: begin
				re      = 1'b1;
				state_d = S_LDATA;
			end
			S_LDATA: begin
				emit     = 1'b1;
				em.entry = rd_a;
				em.slot  = 4'(i_q);
				em.last  = (int'(ip1) == lcnt);
				i_d      = ip1;
			end
			S_SREAD: begin
				re      = 1'b1;
				state_d = S_SCMP;
			end
			S_SCMP: begin
				ops_d = sat_inc(ops_q);
				if (eq) begin
					emit     = 1'b1;
					em.entry = rd_a;
					em.slot  = 4'(i_q);
					em.ops   = (req_q == REQ_REMOVE) ? 7'd0 : ops_d;
				end else if (ip1 == n_q) begin
					emit      = 1'b1;
					em.status = STS_NOT_FOUND;
					em.ops    = (req_q == REQ_REMOVE) ? 7'd0 : ops_d;
				end else begin
					i_d     = ip1;
					state_d = S_SREAD;
				end
			end
			S_CREAD: begin
				re      = 1'b1;
				state_d = S_CCMP;
			end
			S_CCMP: begin
				if (cres.gt) begin
					emit      = 1'b1;
					em.status = STS_UNSORTED;
				end else if (ip1 + 1'b1 == n_q) begin
					lo_d    = '0;
					hic_d   = n_q;
					state_d = S_BREAD;
				end else begin
					i_d     = ip1;
					state_d = S_CREAD;
				end
			end
			S_BREAD: begin
				re      = 1'b1;
				ra      = msum[IW:1];
				mid_d   = msum[IW:1];
				state_d = S_BCMP;
			end
			S_BCMP: begin
				ops_d = sat_inc(ops_q);
				if (cres.lt)
					lo_n = midc + 1'b1;
				else
					hic_n = midc;
				lo_d  = lo_n;
				hic_d = hic_n;
				if (eq) begin
					emit     = 1'b1;
					em.entry = rd_a;
					em.slot  = 4'(mid_q);
					em.ops   = ops_d;
				end else if (lo_n >= hic_n) begin
					emit      = 1'b1;
					em.status = STS_NOT_FOUND;
					em.ops    = ops_d;
				end else
					state_d = S_BREAD;
			end
			S_XREAD: begin
				re      = 1'b1;
				state_d = S_XCMP;
			end
			S_XCMP, S_XW2: begin
				if (state_q == S_XCMP && cres.gt) begin
					ops_d   = sat_inc(ops_q);
					state_d = S_XW1;
				end else begin
					if (state_q == S_XW2) begin
						we    = 1'b1;
						waddr = ip1[IW-1:0];
						wdata = rd_a;
					end
					// End of a pass shortens the next one by one compare.
					if (ip1 == end_q) begin
						if (end_q == CW'(1)) begin
							emit   = 1'b1;
							em.ops = ops_q;
						end else begin
							end_d   = end_q - 1'b1;
							i_d     = '0;
							state_d = S_XREAD;
						end
					end else begin
						i_d     = ip1;
						state_d = S_XREAD;
					end
				end
			end
			S_XW1: begin
				we      = 1'b1;
				wdata   = rd_b;
				state_d = S_XW2;
			end
			S_RREAD: begin
				if (ip1 == n_q) begin
					n_d     = n_q - 1'b1;
					state_d = S_IDLE;
				end else begin
					re      = 1'b1;
					ra      = ip1[IW-1:0];
					state_d = S_RWR;
				end
			end
			S_RWR: begin
				we      = 1'b1;
				i_d     = ip1;
				state_d = S_RREAD;
			end
			S_OWAIT: begin
				if (!out_valid_q)
					state_d = ret_q;
			end
			default: state_d = S_IDLE;
		endcase
		if (emit) begin
			state_d = S_OWAIT;
			ret_d   = S_IDLE;
			if (state_q == S_LDATA && !em.last)
				ret_d = S_LREAD;
			if (state_q == S_SCMP && eq && req_q == REQ_REMOVE)
				ret_d = S_RREAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			i_q         <= '0;
			end_q       <= '0;
			lo_q        <= '0;
			hic_q       <= '0;
			mid_q       <= '0;
			ops_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			n_q   <= n_d;
			i_q   <= i_d;
			end_q <= end_d;
			lo_q  <= lo_d;
			hic_q <= hic_d;
			mid_q <= mid_d;
			ops_q <= ops_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q   <= req_type;
			key_q   <= key_in;
			knorm_q <= kind_in[191:0];
			amt_q   <= amount;
		end
		if (emit)
			out_q <= em;
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign out_name_w0 = out_q.entry.name[63:0];
	assign out_name_w1 = out_q.entry.name[127:64];
	assign out_name_w2 = out_q.entry.name[191:128];
	assign out_name_w3 = out_q.entry.name[255:192];
	assign out_kind_w0 = out_q.entry.kind[63:0];
	assign out_kind_w1 = out_q.entry.kind[127:64];
	assign out_kind_w2 = out_q.entry.kind[191:128];
	assign out_amount  = out_q.entry.amount;
	assign op_count    = out_q.ops;
	assign slot        = out_q.slot;
	assign last        = out_q.last;

	`NKT_ASSERT_NOW(a_out_in_wait, out_valid_q, state_q == S_OWAIT, "result word outside wait state")
	`NKT_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall && req_type <= REQ_REMOVE, in_stall, "known request did not make the block busy")
	`NKT_ASSERT_NOW(a_fill_step, n_q != $past(n_q), (n_q == $past(n_q) + 1'b1) || (n_q + 1'b1 == $past(n_q)), "fill count moved by more than one")
endmodule
